@@ hdl/mdq_pkg.sv @@
// Shared types and codes for the MDIO operation queue.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mdq_pkg;

   // Command codes of an input item.
   localparam logic [3:0] CMD_READ    = 4'd0;
   localparam logic [3:0] CMD_WRITE   = 4'd1;
   localparam logic [3:0] CMD_SCAN    = 4'd2;
   localparam logic [3:0] CMD_QRESULT = 4'd3;
   localparam logic [3:0] CMD_QPHY    = 4'd4;
   localparam logic [3:0] CMD_RELEASE = 4'd5;
   localparam logic [3:0] CMD_ABORT   = 4'd6;
   localparam logic [3:0] CMD_SERVICE = 4'd7;
   localparam logic [3:0] CMD_CLEAR   = 4'd8;

   // Status and completion codes.
   localparam logic [3:0] RES_OK         = 4'd0;
   localparam logic [3:0] RES_PENDING    = 4'd1;
   localparam logic [3:0] RES_BUSY       = 4'd2;
   localparam logic [3:0] RES_BAD_ADDR   = 4'd3;
   localparam logic [3:0] RES_BAD_REG    = 4'd4;
   localparam logic [3:0] RES_BAD_HANDLE = 4'd5;
   localparam logic [3:0] RES_ABORTED    = 4'd6;
   localparam logic [3:0] RES_TIMEOUT    = 4'd7;
   localparam logic [3:0] RES_NOT_FOUND  = 4'd8;

   // Slot life cycle.
   localparam logic [1:0] SLOT_FREE     = 2'd0;
   localparam logic [1:0] SLOT_QUEUED   = 2'd1;
   localparam logic [1:0] SLOT_ACTIVE   = 2'd2;
   localparam logic [1:0] SLOT_COMPLETE = 2'd3;

   // Operation kinds.
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_SCAN  = 2'd2;

   // Phase commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic find;
      logic exec1;
      logic exec2;
   } ctrl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic is_service;
      logic has_active;
      logic fifo_nonempty;
      logic go_second;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hdl/mdq_ctrl.sv @@
// Sequencer of the MDIO operation queue: walks each item through its phases.
// Depends on mdq_pkg.
`default_nettype none

module mdq_ctrl
   import mdq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  dp_status_type      status,
   output logic               busy,
   output logic               rsp_valid,
   output ctrl_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIND  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_EXEC2 = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_FIND;
         end
         S_FIND: begin
            if (status.is_service && !status.has_active) begin
               state_in = status.fifo_nonempty ? S_EXEC2 : S_RESP;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = status.go_second ? S_EXEC2 : S_RESP;
         end
         S_EXEC2: state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign cmd.accept = (state_ff == S_IDLE) && start;
   assign cmd.find   = (state_ff == S_FIND);
   assign cmd.exec1  = (state_ff == S_EXEC);
   assign cmd.exec2  = (state_ff == S_EXEC2);

endmodule

`default_nettype wire

@@ hdl/mdq_datapath.sv @@
// Slot store, order FIFO, handle counter and result registers of the queue.
// Depends on mdq_pkg; sequenced by mdq_ctrl.
`default_nettype none

module mdq_datapath
   import mdq_pkg::*;
#(
   parameter int QUEUE_DEPTH    = 8,
   parameter int TIMEOUT_PASSES = 200,
   parameter int REGISTER_COUNT = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  ctrl_cmd_type     cmd,
   output dp_status_type    status,
   input  wire logic [3:0]  req_command,
   input  wire logic [4:0]  req_phy_address,
   input  wire logic [4:0]  req_register_address,
   input  wire logic [4:0]  req_scan_last,
   input  wire logic [15:0] req_write_value,
   input  wire logic [7:0]  req_handle,
   input  wire logic        req_engine_start_ok,
   input  wire logic        req_engine_idle,
   input  wire logic        req_engine_read_done,
   input  wire logic [15:0] req_engine_read_value,
   output logic [3:0]       rsp_status,
   output logic [7:0]       rsp_handle_out,
   output logic [15:0]      rsp_value_out,
   output logic [4:0]       rsp_phy_out,
   output logic             rsp_progressed,
   output logic             rsp_start_valid,
   output logic             rsp_start_is_write,
   output logic [4:0]       rsp_start_phy,
   output logic [4:0]       rsp_start_reg,
   output logic [15:0]      rsp_start_data,
   output logic             rsp_done_valid,
   output logic [3:0]       rsp_done_result
);

   localparam int IDXW = $clog2(QUEUE_DEPTH + 1);
   localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [IDXW-1:0] NONE = IDXW'(QUEUE_DEPTH);
   localparam logic [PTRW-1:0] PTR_LAST = PTRW'(QUEUE_DEPTH - 1);

   // Latched item.
   logic [3:0]  cmd_ff;
   logic [4:0]  phy_ff, reg_ff, last_ff;
   logic [15:0] wdata_ff, rval_ff;
   logic [7:0]  hdl_ff;
   logic        ok_ff, idle_ff, rdone_ff;

   // Slots and queue bookkeeping.
   logic [1:0]  st_ff   [QUEUE_DEPTH];
   logic [1:0]  st_in   [QUEUE_DEPTH];
   logic [7:0]  hd_ff   [QUEUE_DEPTH];
   logic [7:0]  hd_in   [QUEUE_DEPTH];
   logic [1:0]  kind_ff [QUEUE_DEPTH];
   logic [1:0]  kind_in [QUEUE_DEPTH];
   logic [4:0]  sphy_ff [QUEUE_DEPTH];
   logic [4:0]  sphy_in [QUEUE_DEPTH];
   logic [4:0]  sreg_ff [QUEUE_DEPTH];
   logic [4:0]  sreg_in [QUEUE_DEPTH];
   logic [4:0]  send_ff [QUEUE_DEPTH];
   logic [4:0]  send_in [QUEUE_DEPTH];
   logic [15:0] swd_ff  [QUEUE_DEPTH];
   logic [15:0] swd_in  [QUEUE_DEPTH];
   logic [15:0] srd_ff  [QUEUE_DEPTH];
   logic [15:0] srd_in  [QUEUE_DEPTH];
   logic [3:0]  scode_ff[QUEUE_DEPTH];
   logic [3:0]  scode_in[QUEUE_DEPTH];
   logic [IDXW-1:0] fifo_ff[QUEUE_DEPTH];
   logic [IDXW-1:0] fifo_in[QUEUE_DEPTH];
   logic [PTRW-1:0] rp_ff, rp_in, wp_ff, wp_in;
   logic [IDXW-1:0] cnt_ff, cnt_in, act_ff, act_in, sel_ff, sel_in;
   logic            found_ff, found_in;
   logic [7:0]      pass_ff, pass_in, nh_ff, nh_in;

   // Result registers.
   logic [3:0]  r_status_ff, r_status_in, r_dres_ff, r_dres_in;
   logic [7:0]  r_handle_ff, r_handle_in;
   logic [15:0] r_value_ff, r_value_in, r_sdata_ff, r_sdata_in;
   logic [4:0]  r_phy_ff, r_phy_in, r_sphy_ff, r_sphy_in, r_sreg_ff, r_sreg_in;
   logic        r_prog_ff, r_prog_in, r_sv_ff, r_sv_in, r_sw_ff, r_sw_in;
   logic        r_dv_ff, r_dv_in;

   logic [PTRW-1:0] idx;
   logic            go_second;

   assign idx = sel_ff[PTRW-1:0];

   always_comb begin
      logic [IDXW-1:0] free_idx, match_idx;
      logic            free_found, match_found, finished, is_req;
      logic [7:0]      pass_inc, new_h;
      logic [1:0]      cur_st, cur_kind;
      logic [4:0]      next_phy;

      st_in = st_ff;     hd_in = hd_ff;     kind_in = kind_ff;
      sphy_in = sphy_ff; sreg_in = sreg_ff; send_in = send_ff;
      swd_in = swd_ff;   srd_in = srd_ff;   scode_in = scode_ff;
      fifo_in = fifo_ff;
      rp_in = rp_ff; wp_in = wp_ff; cnt_in = cnt_ff; act_in = act_ff;
      sel_in = sel_ff; found_in = found_ff; pass_in = pass_ff; nh_in = nh_ff;
      r_status_in = r_status_ff; r_handle_in = r_handle_ff;
      r_value_in = r_value_ff;   r_phy_in = r_phy_ff;
      r_prog_in = r_prog_ff;     r_sv_in = r_sv_ff;
      r_sw_in = r_sw_ff;         r_sphy_in = r_sphy_ff;
      r_sreg_in = r_sreg_ff;     r_sdata_in = r_sdata_ff;
      r_dv_in = r_dv_ff;         r_dres_in = r_dres_ff;
      go_second = 1'b0;
      finished = 1'b0;

      // Lowest free slot and lowest slot in use holding the handle.
      free_idx = NONE;
      free_found = 1'b0;
      match_idx = NONE;
      match_found = 1'b0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (st_ff[i] == SLOT_FREE) begin
            free_idx = IDXW'(i);
            free_found = 1'b1;
         end
         if (st_ff[i] != SLOT_FREE && hd_ff[i] == hdl_ff && hdl_ff != 8'd0) begin
            match_idx = IDXW'(i);
            match_found = 1'b1;
         end
      end

      is_req   = (cmd_ff == CMD_READ) || (cmd_ff == CMD_WRITE) || (cmd_ff == CMD_SCAN);
      cur_st   = st_ff[idx];
      cur_kind = kind_ff[idx];
      pass_inc = (pass_ff == 8'hFF) ? 8'hFF : pass_ff + 8'd1;
      next_phy = sphy_ff[idx] + 5'd1;
      new_h    = (nh_ff == 8'd0) ? 8'd1 : nh_ff;

      if (cmd.find) begin
         r_status_in = RES_OK; r_handle_in = 8'd0; r_value_in = 16'd0;
         r_phy_in = 5'd0; r_prog_in = 1'b0; r_sv_in = 1'b0; r_sw_in = 1'b0;
         r_sphy_in = 5'd0; r_sreg_in = 5'd0; r_sdata_in = 16'd0;
         r_dv_in = 1'b0; r_dres_in = RES_OK;
         if (is_req) begin
            sel_in = free_idx;
            found_in = free_found;
         end else if (cmd_ff == CMD_SERVICE) begin
            sel_in = (act_ff < NONE) ? act_ff : fifo_ff[rp_ff];
            found_in = 1'b1;
         end else begin
            sel_in = match_idx;
            found_in = match_found;
         end
      end

      if (cmd.exec1) begin
         case (cmd_ff)
            CMD_READ, CMD_WRITE, CMD_SCAN: begin
               if (cmd_ff == CMD_SCAN && last_ff < phy_ff) begin
                  r_status_in = RES_BAD_ADDR;
               end else if ({1'b0, reg_ff} >= 6'(REGISTER_COUNT)) begin
                  r_status_in = RES_BAD_REG;
               end else if (!found_ff || cnt_ff >= NONE) begin
                  r_status_in = RES_BUSY;
               end else begin
                  fifo_in[wp_ff] = sel_ff;
                  wp_in = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTRW'(1);
                  cnt_in = cnt_ff + IDXW'(1);
                  nh_in = (nh_ff == 8'd0) ? 8'd2 : nh_ff + 8'd1;
                  hd_in[idx] = new_h;
                  kind_in[idx] = cmd_ff[1:0];
                  st_in[idx] = SLOT_QUEUED;
                  sphy_in[idx] = phy_ff;
                  sreg_in[idx] = reg_ff;
                  send_in[idx] = (cmd_ff == CMD_SCAN) ? last_ff : phy_ff;
                  swd_in[idx] = (cmd_ff == CMD_WRITE) ? wdata_ff : 16'd0;
                  srd_in[idx] = 16'd0;
                  scode_in[idx] = RES_PENDING;
                  r_status_in = RES_PENDING;
                  r_handle_in = new_h;
               end
            end
            CMD_QRESULT: begin
               if (!found_ff) begin
                  r_status_in = RES_BAD_HANDLE;
               end else if (cur_st == SLOT_QUEUED || cur_st == SLOT_ACTIVE) begin
                  r_status_in = RES_PENDING;
               end else begin
                  r_status_in = scode_ff[idx];
                  r_value_in = srd_ff[idx];
               end
            end
            CMD_QPHY: begin
               if (!found_ff) begin
                  r_status_in = RES_BAD_HANDLE;
               end else begin
                  r_status_in = scode_ff[idx];
                  r_phy_in = sphy_ff[idx];
               end
            end
            CMD_RELEASE, CMD_ABORT: begin
               if (!found_ff) begin
                  r_status_in = RES_BAD_HANDLE;
               end else if (cur_st == SLOT_ACTIVE ||
                            (cur_st == SLOT_QUEUED && cmd_ff == CMD_RELEASE)) begin
                  r_status_in = RES_BUSY;
               end else if (cur_st == SLOT_QUEUED) begin
                  // Abort of a waiting operation completes it; its FIFO entry
                  // is skipped when it reaches the head.
                  scode_in[idx] = RES_ABORTED;
                  srd_in[idx] = 16'd0;
                  st_in[idx] = SLOT_COMPLETE;
                  r_dv_in = 1'b1;
                  r_dres_in = RES_ABORTED;
                  r_handle_in = hd_ff[idx];
                  r_value_in = 16'd0;
                  r_status_in = RES_OK;
               end else begin
                  st_in[idx] = SLOT_FREE;
                  r_status_in = RES_OK;
               end
            end
            CMD_SERVICE: begin
               // Check the active transfer: finish it on timeout or completion, or step a scan.
               pass_in = pass_inc;
               if (pass_inc > 8'(TIMEOUT_PASSES)) begin
                  finished = 1'b1;
                  scode_in[idx] = RES_TIMEOUT;
                  srd_in[idx] = 16'd0;
                  r_dres_in = RES_TIMEOUT;
                  r_value_in = 16'd0;
               end else if (cur_kind == KIND_WRITE) begin
                  if (idle_ff) begin
                     finished = 1'b1;
                     scode_in[idx] = RES_OK;
                     srd_in[idx] = swd_ff[idx];
                     r_dres_in = RES_OK;
                     r_value_in = swd_ff[idx];
                  end
               end else if (rdone_ff) begin
                  if (cur_kind == KIND_SCAN && (rval_ff == 16'h0000 || rval_ff == 16'hFFFF)) begin
                     if (sphy_ff[idx] >= send_ff[idx]) begin
                        finished = 1'b1;
                        scode_in[idx] = RES_NOT_FOUND;
                        srd_in[idx] = 16'd0;
                        r_dres_in = RES_NOT_FOUND;
                        r_value_in = 16'd0;
                     end else begin
                        sphy_in[idx] = next_phy;
                        r_sv_in = 1'b1;
                        r_sw_in = 1'b0;
                        r_sphy_in = next_phy;
                        r_sreg_in = sreg_ff[idx];
                        r_sdata_in = 16'd0;
                        if (ok_ff) begin
                           pass_in = 8'd0;
                           r_prog_in = 1'b1;
                        end
                     end
                  end else begin
                     finished = 1'b1;
                     scode_in[idx] = RES_OK;
                     srd_in[idx] = rval_ff;
                     r_dres_in = RES_OK;
                     r_value_in = rval_ff;
                  end
               end
               if (finished) begin
                  st_in[idx] = SLOT_COMPLETE;
                  r_dv_in = 1'b1;
                  r_handle_in = hd_ff[idx];
                  act_in = NONE;
                  r_prog_in = 1'b1;
                  go_second = (cnt_ff != '0);
                  sel_in = fifo_ff[rp_ff];
               end
            end
            CMD_CLEAR: begin
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  st_in[i] = SLOT_FREE;
               end
               rp_in = '0;
               wp_in = '0;
               cnt_in = '0;
               act_in = NONE;
               pass_in = 8'd0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.exec2 && sel_ff < NONE) begin
         // Take the next queued slot and ask the engine to start it; skip a slot no longer queued.
         if (cur_st != SLOT_QUEUED) begin
            rp_in = (rp_ff == PTR_LAST) ? '0 : rp_ff + PTRW'(1);
            cnt_in = cnt_ff - IDXW'(1);
            r_prog_in = 1'b1;
         end else begin
            r_sv_in = 1'b1;
            r_sw_in = (cur_kind == KIND_WRITE);
            r_sphy_in = sphy_ff[idx];
            r_sreg_in = sreg_ff[idx];
            r_sdata_in = (cur_kind == KIND_WRITE) ? swd_ff[idx] : 16'd0;
            if (ok_ff) begin
               rp_in = (rp_ff == PTR_LAST) ? '0 : rp_ff + PTRW'(1);
               cnt_in = cnt_ff - IDXW'(1);
               act_in = sel_ff;
               pass_in = 8'd0;
               st_in[idx] = SLOT_ACTIVE;
               r_prog_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            st_ff[i] <= SLOT_FREE;
         end
         rp_ff <= '0;
         wp_ff <= '0;
         cnt_ff <= '0;
         act_ff <= NONE;
         pass_ff <= 8'd0;
         nh_ff <= 8'd1;
      end else begin
         st_ff <= st_in;
         rp_ff <= rp_in;
         wp_ff <= wp_in;
         cnt_ff <= cnt_in;
         act_ff <= act_in;
         pass_ff <= pass_in;
         nh_ff <= nh_in;
      end
   end

   always_ff @(posedge clock) begin
      hd_ff <= hd_in;     kind_ff <= kind_in; sphy_ff <= sphy_in;
      sreg_ff <= sreg_in; send_ff <= send_in; swd_ff <= swd_in;
      srd_ff <= srd_in;   scode_ff <= scode_in; fifo_ff <= fifo_in;
      sel_ff <= sel_in;   found_ff <= found_in;
      r_status_ff <= r_status_in; r_handle_ff <= r_handle_in;
      r_value_ff <= r_value_in;   r_phy_ff <= r_phy_in;
      r_prog_ff <= r_prog_in;     r_sv_ff <= r_sv_in;
      r_sw_ff <= r_sw_in;         r_sphy_ff <= r_sphy_in;
      r_sreg_ff <= r_sreg_in;     r_sdata_ff <= r_sdata_in;
      r_dv_ff <= r_dv_in;         r_dres_ff <= r_dres_in;
      if (cmd.accept) begin
         cmd_ff <= req_command;
         phy_ff <= req_phy_address;
         reg_ff <= req_register_address;
         last_ff <= req_scan_last;
         wdata_ff <= req_write_value;
         hdl_ff <= req_handle;
         ok_ff <= req_engine_start_ok;
         idle_ff <= req_engine_idle;
         rdone_ff <= req_engine_read_done;
         rval_ff <= req_engine_read_value;
      end
   end

   assign status.is_service    = (cmd_ff == CMD_SERVICE);
   assign status.has_active    = (act_ff < NONE);
   assign status.fifo_nonempty = (cnt_ff != '0);
   assign status.go_second     = go_second;

   assign rsp_status         = r_status_ff;
   assign rsp_handle_out     = r_handle_ff;
   assign rsp_value_out      = r_value_ff;
   assign rsp_phy_out        = r_phy_ff;
   assign rsp_progressed     = r_prog_ff;
   assign rsp_start_valid    = r_sv_ff;
   assign rsp_start_is_write = r_sw_ff;
   assign rsp_start_phy      = r_sphy_ff;
   assign rsp_start_reg      = r_sreg_ff;
   assign rsp_start_data     = r_sdata_ff;
   assign rsp_done_valid     = r_dv_ff;
   assign rsp_done_result    = r_dres_ff;

endmodule

`default_nettype wire

@@ hdl/mdio_operation_queue_top.sv @@
// Top level of the MDIO operation queue: controller plus datapath.
// Depends on mdq_pkg, mdq_ctrl and mdq_datapath.
//
//   Channel   Handshake               Fields
//   request   start / busy            req_command ... req_engine_read_value
//   response  rsp_valid (one cycle)   rsp_status ... rsp_done_result
//
// Every item gives exactly one response item. An item is taken when start is
// high and busy is low; busy then stays high until the response strobe.
// Most items pass from acceptance through find, execute and response; a
// service tick that finishes a transfer and then starts the next queued slot
// adds a start phase, since the single slot read port is used once for each.
// A service tick with nothing active and an empty queue skips execute.
// The response is shown for one cycle only and cannot be held off.
// Reset is synchronous: it frees every slot, empties the order FIFO, marks no
// transfer active and sets the next handle to one.
`default_nettype none

module mdio_operation_queue_top
   import mdq_pkg::*;
#(
   parameter int QUEUE_DEPTH    = 8,
   parameter int TIMEOUT_PASSES = 200,
   parameter int REGISTER_COUNT = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_command,
   input  wire logic [4:0]  req_phy_address,
   input  wire logic [4:0]  req_register_address,
   input  wire logic [4:0]  req_scan_last,
   input  wire logic [15:0] req_write_value,
   input  wire logic [7:0]  req_handle,
   input  wire logic        req_engine_start_ok,
   input  wire logic        req_engine_idle,
   input  wire logic        req_engine_read_done,
   input  wire logic [15:0] req_engine_read_value,
   output logic             rsp_valid,
   output logic [3:0]       rsp_status,
   output logic [7:0]       rsp_handle_out,
   output logic [15:0]      rsp_value_out,
   output logic [4:0]       rsp_phy_out,
   output logic             rsp_progressed,
   output logic             rsp_start_valid,
   output logic             rsp_start_is_write,
   output logic [4:0]       rsp_start_phy,
   output logic [4:0]       rsp_start_reg,
   output logic [15:0]      rsp_start_data,
   output logic             rsp_done_valid,
   output logic [3:0]       rsp_done_result
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller sequences the phases: latch the item, look up the slot,
   // execute, optionally start the next queued slot, then strobe the result.
   mdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath holds the slots, the order FIFO and the result registers.
   mdq_datapath #(
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .TIMEOUT_PASSES (TIMEOUT_PASSES),
      .REGISTER_COUNT (REGISTER_COUNT)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_command           (req_command),
      .req_phy_address       (req_phy_address),
      .req_register_address  (req_register_address),
      .req_scan_last         (req_scan_last),
      .req_write_value       (req_write_value),
      .req_handle            (req_handle),
      .req_engine_start_ok   (req_engine_start_ok),
      .req_engine_idle       (req_engine_idle),
      .req_engine_read_done  (req_engine_read_done),
      .req_engine_read_value (req_engine_read_value),
      .rsp_status            (rsp_status),
      .rsp_handle_out        (rsp_handle_out),
      .rsp_value_out         (rsp_value_out),
      .rsp_phy_out           (rsp_phy_out),
      .rsp_progressed        (rsp_progressed),
      .rsp_start_valid       (rsp_start_valid),
      .rsp_start_is_write    (rsp_start_is_write),
      .rsp_start_phy         (rsp_start_phy),
      .rsp_start_reg         (rsp_start_reg),
      .rsp_start_data        (rsp_start_data),
      .rsp_done_valid        (rsp_done_valid),
      .rsp_done_result       (rsp_done_result)
   );

   // An accepted item keeps the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   // The response strobe comes only while busy and lasts one cycle.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (busy ##1 !busy))
      else $error("response strobe outside a busy period");

   // A second phase is only entered for a service tick.
   a_second_phase: assert property (@(posedge clock) disable iff (reset)
      cmd.exec2 |-> status.is_service)
      else $error("start phase for an item that is not a service tick");

endmodule

`default_nettype wire
